[rtl/touch_tap_hold_recognizer_unit_defines.svh]
// Assertion macros used by the checker file of the recognizer
`ifndef TOUCH_TAP_HOLD_RECOGNIZER_UNIT_DEFINES_SVH
`define TOUCH_TAP_HOLD_RECOGNIZER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TTHR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tthr same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define TTHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tthr next-cycle check failed");

`endif

[rtl/tthr_pkg.sv]
package tthr_pkg;

    localparam int PosW   = 12;
    localparam int TimeW  = 32;
    localparam int CountW = 4;
    localparam int SlopW  = 10;
    localparam int MsW    = 16;
    localparam int SlopSqW = 2 * SlopW;

    // smallest effective slop radius
    localparam logic [SlopW-1:0] SlopMin = SlopW'(10);

    // register reset values
    localparam logic [SlopW-1:0]   SlopRst    = SlopW'(24);
    localparam logic [SlopSqW-1:0] SlopSqRst  = SlopSqW'(576);
    localparam logic [MsW-1:0]     LongRst    = MsW'(400);
    localparam logic [MsW-1:0]     TwoMaxRst  = MsW'(500);

    // register indexes
    localparam logic [1:0] RegSlop    = 2'd0;
    localparam logic [1:0] RegLong    = 2'd1;
    localparam logic [1:0] RegTwoMax  = 2'd2;

    typedef struct packed {
        logic [CountW-1:0] finger_count;
        logic [PosW-1:0]   pos_x;
        logic [PosW-1:0]   pos_y;
        logic [TimeW-1:0]  now_ms;
    } t_sample;

    typedef struct packed {
        logic            finger_down;
        logic            hold_event;
        logic [PosW-1:0] press_x;
        logic [PosW-1:0] press_y;
        logic            tap;
        logic [PosW-1:0] tap_x;
        logic [PosW-1:0] tap_y;
        logic            two_finger_tap;
        logic            any_event;
    } t_result;

    typedef struct packed {
        logic [SlopSqW-1:0] slop_sq;
        logic [MsW-1:0]     hold_ms;
        logic [MsW-1:0]     two_finger_max_ms;
    } t_cfg;

endpackage

[rtl/tthr_cfg.sv]
module tthr_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output tthr_pkg::t_cfg  o_cfg
);
    import tthr_pkg::*;

    logic [SlopW-1:0]   r_slop_px;
    logic [SlopSqW-1:0] r_slop_sq;
    logic [MsW-1:0]     r_hold_ms;
    logic [MsW-1:0]     r_two_finger_max_ms;

    logic               wr_en;
    logic [1:0]         reg_idx;
    logic [SlopW-1:0]   slop_clamped;
    logic [SlopSqW-1:0] n_slop_sq;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // clamp and square the slop once, at write time
    assign slop_clamped = (pwdata[SlopW-1:0] < SlopMin) ? SlopMin : pwdata[SlopW-1:0];
    assign n_slop_sq    = SlopSqW'(slop_clamped) * SlopSqW'(slop_clamped);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slop_px           <= SlopRst;
            r_slop_sq           <= SlopSqRst;
            r_hold_ms           <= LongRst;
            r_two_finger_max_ms <= TwoMaxRst;
        end else if (wr_en) begin
            unique case (reg_idx)
                RegSlop: begin
                    r_slop_px <= pwdata[SlopW-1:0];
                    r_slop_sq <= n_slop_sq;
                end
                RegLong:   r_hold_ms           <= pwdata[MsW-1:0];
                RegTwoMax: r_two_finger_max_ms <= pwdata[MsW-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            RegSlop:   prdata = 32'(r_slop_px);
            RegLong:   prdata = 32'(r_hold_ms);
            RegTwoMax: prdata = 32'(r_two_finger_max_ms);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.slop_sq           = r_slop_sq;
    assign o_cfg.hold_ms           = r_hold_ms;
    assign o_cfg.two_finger_max_ms = r_two_finger_max_ms;

endmodule

[rtl/tthr_core.sv]
module tthr_core #(
    parameter int MAX_FINGERS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tthr_pkg::t_sample i_sample,
    input  tthr_pkg::t_cfg    i_cfg,
    output tthr_pkg::t_result o_result
);
    import tthr_pkg::*;

    localparam logic [CountW-1:0] MaxF = CountW'(MAX_FINGERS);
    localparam logic [CountW-1:0] Two  = CountW'(2);

    // sequence state
    logic              r_active;
    logic [PosW-1:0]   r_origin_x, r_origin_y;
    logic [PosW-1:0]   r_last_x, r_last_y;
    logic [TimeW-1:0]  r_start;
    logic [CountW-1:0] r_peak;
    logic              r_moved, r_held;

    logic              n_active;
    logic [PosW-1:0]   n_origin_x, n_origin_y;
    logic [PosW-1:0]   n_last_x, n_last_y;
    logic [TimeW-1:0]  n_start;
    logic [CountW-1:0] n_peak;
    logic              n_moved, n_held;

    logic [CountW-1:0] np;
    logic [PosW-1:0]   org_x, org_y;
    logic [TimeW-1:0]  t_base;
    logic [TimeW-1:0]  elapsed;
    logic signed [PosW:0] dx, dy;
    logic [PosW:0]     ndx, ndy;
    logic [PosW-1:0]   ax, ay;
    logic [2*PosW-1:0] sqx, sqy;
    logic [2*PosW:0]   d2;
    logic              far;
    t_result           res;

    assign np = (i_sample.finger_count > MaxF) ? MaxF : i_sample.finger_count;

    // origin and start time as this sample sees them
    assign org_x  = r_active ? r_origin_x : i_sample.pos_x;
    assign org_y  = r_active ? r_origin_y : i_sample.pos_y;
    assign t_base = r_active ? r_start : i_sample.now_ms;

    // squared distance from the origin seen by this sample
    assign dx  = $signed({1'b0, i_sample.pos_x}) - $signed({1'b0, org_x});
    assign dy  = $signed({1'b0, i_sample.pos_y}) - $signed({1'b0, org_y});
    assign ndx = (PosW+1)'(-dx);
    assign ndy = (PosW+1)'(-dy);
    assign ax  = dx[PosW] ? ndx[PosW-1:0] : dx[PosW-1:0];
    assign ay  = dy[PosW] ? ndy[PosW-1:0] : dy[PosW-1:0];
    assign sqx = (2*PosW)'(ax) * (2*PosW)'(ax);
    assign sqy = (2*PosW)'(ay) * (2*PosW)'(ay);
    assign d2  = {1'b0, sqx} + {1'b0, sqy};
    assign far = d2 > (2*PosW+1)'(i_cfg.slop_sq);

    assign elapsed = i_sample.now_ms - t_base;

    // next state and result
    always_comb begin
        n_active   = r_active;
        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_start    = r_start;
        n_peak     = r_peak;
        n_moved    = r_moved;
        n_held     = r_held;
        res        = '0;

        if (np != '0) begin
            // a new sequence starts from this sample
            if (!r_active) begin
                n_active   = 1'b1;
                n_origin_x = i_sample.pos_x;
                n_origin_y = i_sample.pos_y;
                n_last_x   = i_sample.pos_x;
                n_last_y   = i_sample.pos_y;
                n_start    = i_sample.now_ms;
                n_moved    = 1'b0;
                n_held     = 1'b0;
                n_peak     = np;
            end else if (np > r_peak) begin
                n_peak = np;
            end
            // single finger: track position, long press
            if (n_peak < Two) begin
                n_moved         = n_moved | far;
                n_last_x        = i_sample.pos_x;
                n_last_y        = i_sample.pos_y;
                res.finger_down = ~n_moved;
                if (!n_moved && !n_held && (elapsed >= TimeW'(i_cfg.hold_ms))) begin
                    n_held         = 1'b1;
                    res.hold_event = 1'b1;
                    res.press_x    = n_origin_x;
                    res.press_y    = n_origin_y;
                end
            end
        end else if (r_active) begin
            // release ends the sequence
            priority if (r_peak >= Two) begin
                res.two_finger_tap = elapsed < TimeW'(i_cfg.two_finger_max_ms);
            end else if (!r_moved && !r_held) begin
                res.tap   = 1'b1;
                res.tap_x = r_last_x;
                res.tap_y = r_last_y;
            end else begin
                // moved or already held: the release reports nothing
                res.tap = 1'b0;
            end
            n_active = 1'b0;
        end
        res.any_event = res.tap | res.two_finger_tap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_start    <= '0;
            r_peak     <= '0;
            r_moved    <= 1'b0;
            r_held     <= 1'b0;
        end else if (i_step) begin
            r_active   <= n_active;
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            r_last_x   <= n_last_x;
            r_last_y   <= n_last_y;
            r_start    <= n_start;
            r_peak     <= n_peak;
            r_moved    <= n_moved;
            r_held     <= n_held;
        end
    end

    assign o_result = res;

endmodule

[rtl/touch_tap_hold_recognizer_unit.sv]
// Channel   | Handshake                  | Payload
// ----------+----------------------------+--------------------------------------------
// sample in | i_in_valid / o_in_ready    | i_finger_count, i_pos_x, i_pos_y, i_now_ms
// result    | o_out_valid / i_out_ready  | o_finger_down ... o_any_event
// config    | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// An input register, then the step logic into the result register. One sample per cycle is
// sustained unless stalled; the sequence state updates as each result is registered.
// A stalled result holds the input register; the input side stalls only when both are full.
// Synchronous active-low reset clears the sequence state and loads the register defaults.
module touch_tap_hold_recognizer_unit #(
    parameter int MAX_FINGERS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_finger_count,
    input  logic [11:0] i_pos_x,
    input  logic [11:0] i_pos_y,
    input  logic [31:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_finger_down,
    output logic        o_hold_event,
    output logic [11:0] o_press_x,
    output logic [11:0] o_press_y,
    output logic        o_tap,
    output logic [11:0] o_tap_x,
    output logic [11:0] o_tap_y,
    output logic        o_two_finger_tap,
    output logic        o_any_event,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tthr_pkg::*;

    logic    r_in_valid, r_out_valid;
    t_sample r_in;
    t_result r_res;
    t_result step_res;
    t_cfg    cfg;
    logic    advance;

    // pipeline control
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.finger_count <= i_finger_count;
            r_in.pos_x        <= i_pos_x;
            r_in.pos_y        <= i_pos_y;
            r_in.now_ms       <= i_now_ms;
        end
        if (advance) r_res <= step_res;
    end

    tthr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tthr_core #(
        .MAX_FINGERS (MAX_FINGERS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_sample (r_in),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    assign o_out_valid      = r_out_valid;
    assign o_finger_down    = r_res.finger_down;
    assign o_hold_event     = r_res.hold_event;
    assign o_press_x        = r_res.press_x;
    assign o_press_y        = r_res.press_y;
    assign o_tap            = r_res.tap;
    assign o_tap_x          = r_res.tap_x;
    assign o_tap_y          = r_res.tap_y;
    assign o_two_finger_tap = r_res.two_finger_tap;
    assign o_any_event      = r_res.any_event;

endmodule

[rtl/tthr_checker.sv]
`include "touch_tap_hold_recognizer_unit_defines.svh"

module tthr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_finger_down,
    input logic        o_hold_event,
    input logic [11:0] o_press_x,
    input logic [11:0] o_press_y,
    input logic        o_tap,
    input logic [11:0] o_tap_x,
    input logic [11:0] o_tap_y,
    input logic        o_two_finger_tap,
    input logic        o_any_event
);

    logic [49:0] held_view;

    // payload that must not move while the result waits
    assign held_view = {o_press_x, o_press_y, o_tap_x, o_tap_y, o_any_event, o_hold_event};

    // any_event is exactly the OR of the two release events
    `TTHR_ASSERT_NOW(a_any_event, i_clk, i_rst_n, o_out_valid, o_any_event == (o_tap | o_two_finger_tap))

    // a release cannot be both a tap and a two-finger tap
    `TTHR_ASSERT_NOW(a_tap_excl, i_clk, i_rst_n, o_out_valid, !(o_tap && o_two_finger_tap))

    // long press only fires on an unmoved finger still down
    `TTHR_ASSERT_NOW(a_press_down, i_clk, i_rst_n, o_out_valid && o_hold_event, o_finger_down && !o_tap)

    // a stalled result holds its transaction
    `TTHR_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(held_view))

endmodule

bind touch_tap_hold_recognizer_unit tthr_checker u_tthr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_finger_down    (o_finger_down),
    .o_hold_event     (o_hold_event),
    .o_press_x        (o_press_x),
    .o_press_y        (o_press_y),
    .o_tap            (o_tap),
    .o_tap_x          (o_tap_x),
    .o_tap_y          (o_tap_y),
    .o_two_finger_tap (o_two_finger_tap),
    .o_any_event      (o_any_event)
);

[sim/touch_tap_hold_recognizer_unit_test.sv]
module touch_tap_hold_recognizer_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tthr_pkg::*;

    localparam int MaxFingers = 8;
    localparam int StallLimit = 2000;
    localparam int HoldOffAt = 150;
    localparam int HoldOffCycles = 80;
    localparam int ReportCap = 40;

    // who idles: sender light / receiver heavy, the reverse, or nobody
    typedef enum logic [1:0] {
        StyleBackpressure,
        StyleStarved,
        StyleFullRate
    } t_idle_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_finger_count = '0;
    logic [11:0] i_pos_x = '0;
    logic [11:0] i_pos_y = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_finger_down;
    logic        o_hold_event;
    logic [11:0] o_press_x;
    logic [11:0] o_press_y;
    logic        o_tap;
    logic [11:0] o_tap_x;
    logic [11:0] o_tap_y;
    logic        o_two_finger_tap;
    logic        o_any_event;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    touch_tap_hold_recognizer_unit #(
        .MAX_FINGERS(MaxFingers)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_finger_count(i_finger_count),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_now_ms(i_now_ms),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_finger_down(o_finger_down),
        .o_hold_event(o_hold_event),
        .o_press_x(o_press_x),
        .o_press_y(o_press_y),
        .o_tap(o_tap),
        .o_tap_x(o_tap_x),
        .o_tap_y(o_tap_y),
        .o_two_finger_tap(o_two_finger_tap),
        .o_any_event(o_any_event),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // stimulus and expectation stores
    t_sample     pending_samples[$];
    t_result     expected_results[$];
    t_idle_style idle_style = StyleBackpressure;
    int          samples_queued = 0;
    int          samples_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    int          settings_used = 0;
    int          taps_seen = 0;
    int          presses_seen = 0;
    int          escapes_seen = 0;
    logic [31:0] wall_ms = '0;

    // register copies, reset values
    logic [9:0]  cfg_slop = 10'd24;
    logic [15:0] cfg_long = 16'd400;
    logic [15:0] cfg_two = 16'd500;

    // gesture tracker state
    logic        seq_on = 1'b0;
    logic [11:0] org_x = '0, org_y = '0;
    logic [11:0] lst_x = '0, lst_y = '0;
    logic [31:0] t_start = '0;
    int          peak = 0;
    logic        moved = 1'b0;
    logic        held = 1'b0;

    function automatic int eff_slop();
        return (cfg_slop < SlopMin) ? int'(SlopMin) : int'(cfg_slop);
    endfunction

    // advance the gesture tracker by one sample and return what it reports
    function automatic t_result step_gesture(t_sample s);
        t_result     res;
        int          fingers;
        int          dx, dy, rad;
        logic [31:0] elapsed;
        res = '0;
        fingers = (s.finger_count > MaxFingers) ? MaxFingers : int'(s.finger_count);
        if (fingers > 0) begin
            if (!seq_on) begin
                seq_on = 1'b1;
                org_x = s.pos_x;
                org_y = s.pos_y;
                lst_x = s.pos_x;
                lst_y = s.pos_y;
                t_start = s.now_ms;
                peak = 0;
                moved = 1'b0;
                held = 1'b0;
            end
            if (fingers > peak) peak = fingers;
            // position is only tracked while the sequence stayed single-finger
            if (peak < 2) begin
                dx = int'(s.pos_x) - int'(org_x);
                dy = int'(s.pos_y) - int'(org_y);
                rad = eff_slop();
                if (dx * dx + dy * dy > rad * rad) moved = 1'b1;
                lst_x = s.pos_x;
                lst_y = s.pos_y;
                res.finger_down = !moved;
                elapsed = s.now_ms - t_start;
                if (!moved && !held && elapsed >= 32'(cfg_long)) begin
                    held = 1'b1;
                    res.hold_event = 1'b1;
                    res.press_x = org_x;
                    res.press_y = org_y;
                end
            end
        end else if (seq_on) begin
            // release ends the sequence
            elapsed = s.now_ms - t_start;
            if (peak >= 2) begin
                res.two_finger_tap = (elapsed < 32'(cfg_two));
            end else if (!moved && !held) begin
                res.tap = 1'b1;
                res.tap_x = lst_x;
                res.tap_y = lst_y;
            end
            seq_on = 1'b0;
        end
        res.any_event = res.tap | res.two_finger_tap;
        return res;
    endfunction

    task automatic push_sample(int fingers, int x, int y, logic [31:0] stamp);
        t_sample s;
        s.finger_count = 4'(fingers);
        s.pos_x = 12'((x < 0) ? 0 : (x > 4095) ? 4095 : x);
        s.pos_y = 12'((y < 0) ? 0 : (y > 4095) ? 4095 : y);
        s.now_ms = stamp;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // queue one touch sequence of a random kind, with random content
    task automatic queue_gesture();
        int          kind, ox, oy, n, rad, span, sx, sy, dur, fingers;
        logic [31:0] t0;
        kind = $urandom_range(0, 99);
        rad = eff_slop();
        span = rad / 2;
        ox = $urandom_range(0, 4095);
        oy = $urandom_range(0, 4095);
        t0 = wall_ms;
        if (kind < 25) begin
            // plain tap: wiggle inside the slop, mostly quicker than the hold time
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                push_sample(1, ox + jitter(span), oy + jitter(span), wall_ms);
                wall_ms += $urandom_range(0, cfg_long / (n + 1) + 1);
            end
            push_sample(0, $urandom_range(0, 4095), $urandom_range(0, 4095), wall_ms);
        end else if (kind < 45) begin
            // hold: either right on the threshold or in coarse steps past it
            push_sample(1, ox, oy, wall_ms);
            if ($urandom_range(0, 1) == 1) begin
                push_sample(1, ox + jitter(span), oy + jitter(span), t0 + cfg_long - 1);
                push_sample(1, ox + jitter(span), oy + jitter(span), t0 + cfg_long);
                wall_ms = t0 + cfg_long;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    wall_ms += $urandom_range(cfg_long / 3, cfg_long / 2 + 1);
                    push_sample(1, ox + jitter(span), oy + jitter(span), wall_ms);
                end
            end
            wall_ms += $urandom_range(0, 50);
            push_sample(0, ox, oy, wall_ms);
        end else if (kind < 60) begin
            // swipe: walk away from the origin in steps of half the slop
            sx = ($urandom_range(0, 1) == 1) ? 1 : -1;
            sy = ($urandom_range(0, 1) == 1) ? 1 : -1;
            n = $urandom_range(2, 5);
            for (int i = 0; i < n; i++) begin
                push_sample(1, ox + sx * i * (span + 1) + jitter(2),
                            oy + sy * i * $urandom_range(0, span + 1), wall_ms);
                wall_ms += $urandom_range(0, cfg_long / 4 + 1);
            end
            push_sample(0, ox, oy, wall_ms);
        end else if (kind < 70) begin
            // right on the slop circle, then maybe one pixel outside it
            ox = $urandom_range(1024, 3071);
            oy = $urandom_range(1024, 3071);
            push_sample(1, ox, oy, wall_ms);
            push_sample(1, ox + rad, oy, wall_ms + 1);
            push_sample(1, ox, oy - rad, wall_ms + 2);
            if ($urandom_range(0, 1) == 1) push_sample(1, ox + rad, oy + 1, wall_ms + 3);
            else push_sample(1, ox - rad, oy, wall_ms + 3);
            wall_ms += 4 + $urandom_range(0, 20);
            push_sample(0, ox, oy, wall_ms);
        end else if (kind < 90) begin
            // multi-finger sequence with a duration around the escape limit
            case ($urandom_range(0, 3))
                0: dur = (cfg_two > 0) ? int'(cfg_two) - 1 : 0;
                1: dur = int'(cfg_two);
                default: dur = $urandom_range(0, 2 * int'(cfg_two) + 2);
            endcase
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if (i == 0) fingers = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 15);
                else if (i == 1 && fingers == 1) fingers = $urandom_range(2, 15);
                else fingers = $urandom_range(1, 15);
                push_sample(fingers, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            t0 + 32'(longint'(dur) * i / n));
            end
            wall_ms = t0 + 32'(dur);
            push_sample(0, $urandom_range(0, 4095), $urandom_range(0, 4095), wall_ms);
        end else begin
            // noise: anything the fields allow, including wild timestamps
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 2) == 0) wall_ms = $urandom();
                else wall_ms += $urandom_range(0, 300);
                push_sample($urandom_range(0, 15), $urandom_range(0, 4095),
                            $urandom_range(0, 4095), wall_ms);
            end
        end
        wall_ms += $urandom_range(0, 2000);
    endtask

    // register write: a setup phase, then an access phase
    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            RegSlop:   cfg_slop = 10'(value);
            RegLong:   cfg_long = 16'(value);
            RegTwoMax: cfg_two = 16'(value);
            default: ;
        endcase
    endtask

    task automatic configure(int slop, int hold_ms, int two_ms);
        write_reg(RegSlop, slop);
        write_reg(RegLong, hold_ms);
        write_reg(RegTwoMax, two_ms);
        settings_used++;
    endtask

    // wait until every queued transaction has come back, then let the pipe drain
    task automatic settle();
        while (pending_samples.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int slop, int hold_ms, int two_ms, t_idle_style style,
                             int count);
        int stop_at;
        configure(slop, hold_ms, two_ms);
        idle_style = style;
        if ($urandom_range(0, 2) == 0) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else wall_ms = $urandom();
        stop_at = samples_queued + count;
        while (samples_queued < stop_at) queue_gesture();
        settle();
    endtask

    // sample driver
    always @(posedge i_clk) begin : drive_samples
        t_sample nxt;
        int      gap_pct;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(
                    step_gesture({i_finger_count, i_pos_x, i_pos_y, i_now_ms}));
                samples_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                gap_pct = (idle_style == StyleBackpressure) ? 36 :
                          (idle_style == StyleStarved) ? 76 : 0;
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                    nxt = pending_samples.pop_front();
                    i_finger_count <= nxt.finger_count;
                    i_pos_x <= nxt.pos_x;
                    i_pos_y <= nxt.pos_y;
                    i_now_ms <= nxt.now_ms;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with one long hold-off to fill the pipe
    int  hold_left = 0;
    logic hold_done = 1'b0;
    always @(posedge i_clk) begin : drive_ready
        int stall_pct;
        stall_pct = (idle_style == StyleBackpressure) ? 76 :
                    (idle_style == StyleStarved) ? 36 : 0;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HoldOffAt) begin
            hold_done = 1'b1;
            hold_left = HoldOffCycles;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= ReportCap)
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // result monitor
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportCap)
                    $display("%0t: expected no transaction, got finger_down=%0d tap=%0d",
                             $time, o_finger_down, o_tap);
            end else begin
                want = expected_results.pop_front();
                taps_seen += int'(want.tap);
                presses_seen += int'(want.hold_event);
                escapes_seen += int'(want.two_finger_tap);
                check_field("finger_down", 32'(want.finger_down), 32'(o_finger_down));
                check_field("hold_event", 32'(want.hold_event), 32'(o_hold_event));
                check_field("press_x", 32'(want.press_x), 32'(o_press_x));
                check_field("press_y", 32'(want.press_y), 32'(o_press_y));
                check_field("tap", 32'(want.tap), 32'(o_tap));
                check_field("tap_x", 32'(want.tap_x), 32'(o_tap_x));
                check_field("tap_y", 32'(want.tap_y), 32'(o_tap_y));
                check_field("two_finger_tap", 32'(want.two_finger_tap),
                            32'(o_two_finger_tap));
                check_field("any_event", 32'(want.any_event), 32'(o_any_event));
            end
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // directed, reset settings: slop 24, hold 400, escape limit 500
        push_sample(0, 0, 0, 32'd0);                    // release with nothing active
        push_sample(0, 4095, 4095, 32'hFFFF_FFFF);
        push_sample(1, 4095, 4095, 32'd100);            // tap, reported at last position
        push_sample(1, 4090, 4095, 32'd150);
        push_sample(0, 0, 0, 32'd200);
        push_sample(1, 0, 0, 32'd1000);                 // hold fires exactly at 400 ms
        push_sample(1, 0, 0, 32'd1399);
        push_sample(1, 0, 0, 32'd1400);
        push_sample(1, 0, 0, 32'd1500);
        push_sample(0, 0, 0, 32'd1600);
        push_sample(1, 2000, 2000, 32'd3000);           // on the slop circle, then past it
        push_sample(1, 2024, 2000, 32'd3010);
        push_sample(1, 2025, 2000, 32'd3020);
        push_sample(0, 0, 0, 32'd3030);
        push_sample(2, 100, 100, 32'd5000);             // escape just inside the limit
        push_sample(0, 0, 0, 32'd5499);
        push_sample(1, 7, 9, 32'd6000);                 // escape exactly at the limit
        push_sample(2, 7, 9, 32'd6100);
        push_sample(0, 0, 0, 32'd6500);
        push_sample(15, 4095, 0, 32'hFFFF_FF00);        // too many fingers, time wraps
        push_sample(0, 0, 0, 32'h0000_00F0);
        settle();

        // directed: slop under ten, zero hold time, zero escape limit
        configure(3, 0, 0);
        push_sample(1, 100, 100, 32'd0);
        push_sample(1, 110, 100, 32'd1);
        push_sample(0, 0, 0, 32'd2);
        push_sample(3, 50, 60, 32'd10);
        push_sample(0, 0, 0, 32'd10);
        settle();

        // random sequences over a spread of settings
        run_phase(24, 400, 500, StyleBackpressure, 330);
        run_phase(0, 1, 1, StyleBackpressure, 300);
        run_phase(1023, 65535, 65535, StyleStarved, 300);
        run_phase($urandom_range(0, 40), $urandom_range(0, 600), $urandom_range(0, 900),
                  StyleStarved, 330);
        run_phase($urandom_range(0, 1023), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  StyleFullRate, 330);
        run_phase(10, 0, 65535, StyleFullRate, 330);

        $display("Sent %0d samples under %0d register settings, %0d results checked.",
                 samples_sent, settings_used, results_seen);
        $display("Saw %0d taps, %0d long presses and %0d two-finger taps.",
                 taps_seen, presses_seen, escapes_seen);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
